// ===== hdl/cht_pkg.sv =====
// Shared types, codes and constants of the chained hash table.
package cht_pkg;

  localparam int unsigned DefBuckets   = 512;
  localparam int unsigned DefEntries   = 1024;
  localparam int unsigned DefValueBits = 32;

  localparam int unsigned KindBits   = 2;
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned StatusBits = 2;

  localparam logic [KindBits-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindBits-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KindBits-1:0] KIND_REMOVE = 2'd2;

  localparam logic [StatusBits-1:0] ST_OK        = 2'd0;
  localparam logic [StatusBits-1:0] ST_PRESENT   = 2'd1;
  localparam logic [StatusBits-1:0] ST_POOL_FULL = 2'd2;
  localparam logic [StatusBits-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [31:0] HashXor = 32'h7FFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  accept;
    logic                  hash1;
    logic                  hash2;
    logic                  hash3;
    logic                  clr_wr;
    logic                  head_load;
    logic                  compare;
    logic                  found_load;
    logic                  alloc_rd;
    logic                  alloc_wr;
    logic                  unlink_wr;
    logic                  free_wr;
    logic                  out_load;
    logic [StatusBits-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                clr_last;
    logic                cur_nil;
    logic                key_match;
    logic                free_nil;
    logic                out_busy;
    logic [KindBits-1:0] kind;
  } stat_t;

endpackage

// ===== hdl/chained_hash_table.sv =====
// Chained hash table top level: stream ports around controller and datapath.
// Each request (insert, search or remove of a 64-bit key) answers with one result.
// A request walks its bucket's chain entry by entry; a match ends the walk. An insert
// of a new key adds the allocation read and write steps, and a remove of a present key
// adds unlink and release steps. A request with the unused kind code skips the walk.
// The walk is bound by the one-read-per-cycle entry memories, whose read is registered.
// After reset the bucket head memory is cleared one bucket per cycle (BUCKETS buckets,
// 512 by default) and no request is accepted until that finishes. A result waits in the
// output register while the next request is accepted; while that register is still
// full, a finished request holds the sequencer until the result is taken.
module chained_hash_table #(
  parameter int unsigned BUCKETS    = cht_pkg::DefBuckets,
  parameter int unsigned ENTRIES    = cht_pkg::DefEntries,
  parameter int unsigned VALUE_BITS = cht_pkg::DefValueBits,
  localparam int unsigned IdxW      = $clog2(ENTRIES + 1),
  localparam int unsigned InBits    = cht_pkg::KeyBits + VALUE_BITS,
  localparam int unsigned InW       = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits   = cht_pkg::StatusBits + VALUE_BITS + IdxW,
  localparam int unsigned OutW      = ((OutBits + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [InW-1:0]               s_axis_tdata,  // key, value
  input  logic [cht_pkg::KindBits-1:0] s_axis_tuser,  // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OutW-1:0]              m_axis_tdata   // status, found_value, entry_count
);

  cht_pkg::cmd_t                    cmd;
  cht_pkg::stat_t                   stat;
  logic [cht_pkg::StatusBits-1:0]   out_status;
  logic [VALUE_BITS-1:0]            out_found;
  logic [IdxW-1:0]                  out_count;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  cht_dpath #(.Buckets(BUCKETS), .Entries(ENTRIES), .ValueBits(VALUE_BITS)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .kind_i(s_axis_tuser),
    .key_i(s_axis_tdata[cht_pkg::KeyBits-1:0]),
    .value_i(s_axis_tdata[cht_pkg::KeyBits +: VALUE_BITS]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_status_o(out_status),
    .out_found_o(out_found),
    .out_count_o(out_count)
  );

  assign m_axis_tdata = OutW'({out_count, out_found, out_status});

endmodule

// ===== hdl/cht_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cht_ctrl.sv =====
// Operation sequencer of the chained hash table.
module cht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cht_pkg::stat_t stat_i,
  output cht_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_HASH3, S_HEAD_RD, S_HEAD_LD,
    S_CHECK, S_COMPARE, S_ALLOC_RD, S_ALLOC_WR, S_UNLINK, S_RELEASE, S_DONE
  } state_e;

  state_e                           state_q, state_d;
  logic [cht_pkg::StatusBits-1:0]   status_q, status_d;
  cht_pkg::cmd_t                    cmd;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd      = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = S_HASH1;
        end
      end
      S_HASH1: begin
        cmd.hash1 = 1'b1;
        if (stat_i.kind != cht_pkg::KIND_INSERT && stat_i.kind != cht_pkg::KIND_SEARCH &&
            stat_i.kind != cht_pkg::KIND_REMOVE) begin
          status_d = cht_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          state_d = S_HASH2;
        end
      end
      S_HASH2: begin
        cmd.hash2 = 1'b1;
        state_d   = S_HASH3;
      end
      S_HASH3: begin
        cmd.hash3 = 1'b1;
        state_d   = S_HEAD_RD;
      end
      S_HEAD_RD: state_d = S_HEAD_LD;
      S_HEAD_LD: begin
        cmd.head_load = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        if (!stat_i.cur_nil) begin
          state_d = S_COMPARE;
        end else if (stat_i.kind != cht_pkg::KIND_INSERT) begin
          status_d = cht_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end else if (stat_i.free_nil) begin
          status_d = cht_pkg::ST_POOL_FULL;
          state_d  = S_DONE;
        end else begin
          state_d = S_ALLOC_RD;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        if (!stat_i.key_match) begin
          state_d = S_CHECK;
        end else if (stat_i.kind == cht_pkg::KIND_INSERT) begin
          status_d = cht_pkg::ST_PRESENT;
          state_d  = S_DONE;
        end else begin
          cmd.found_load = 1'b1;
          status_d       = cht_pkg::ST_OK;
          state_d        = (stat_i.kind == cht_pkg::KIND_REMOVE) ? S_UNLINK : S_DONE;
        end
      end
      S_ALLOC_RD: begin
        cmd.alloc_rd = 1'b1;
        state_d      = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        status_d     = cht_pkg::ST_OK;
        state_d      = S_DONE;
      end
      S_UNLINK: begin
        cmd.unlink_wr = 1'b1;
        state_d       = S_RELEASE;
      end
      S_RELEASE: begin
        cmd.free_wr = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!stat_i.out_busy) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd.res_status = status_q;
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      status_q <= cht_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== hdl/cht_dpath.sv =====
// Hash, table memories, pointers and output register of the chained hash table.
module cht_dpath #(
  parameter int unsigned Buckets   = cht_pkg::DefBuckets,
  parameter int unsigned Entries   = cht_pkg::DefEntries,
  parameter int unsigned ValueBits = cht_pkg::DefValueBits,
  localparam int unsigned IdxW     = $clog2(Entries + 1),
  localparam int unsigned AddrW    = $clog2(Entries),
  localparam int unsigned BktW     = $clog2(Buckets)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cht_pkg::cmd_t                  cmd_i,
  output cht_pkg::stat_t                 stat_o,
  input  logic [cht_pkg::KindBits-1:0]   kind_i,
  input  logic [cht_pkg::KeyBits-1:0]    key_i,
  input  logic [ValueBits-1:0]           value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cht_pkg::StatusBits-1:0] out_status_o,
  output logic [ValueBits-1:0]           out_found_o,
  output logic [IdxW-1:0]                out_count_o
);

  localparam logic [IdxW-1:0] Nil = IdxW'(Entries);

  logic [cht_pkg::KindBits-1:0] kind_q;
  logic [cht_pkg::KeyBits-1:0]  key_q;
  logic [ValueBits-1:0]         val_q;
  logic [63:0]                  h_q;
  logic [63:0]                  t1, t2, t3;
  logic [31:0]                  hmix;
  logic [BktW-1:0]              bkt;
  logic [IdxW-1:0]              cur_q, prev_q, head_q, nxt_q, free_q, hw_q, count_q;
  logic [ValueBits-1:0]         found_q;
  logic [BktW-1:0]              clr_q;

  logic                         out_valid_q;
  logic [cht_pkg::StatusBits-1:0] out_status_q;
  logic [ValueBits-1:0]         out_found_q;
  logic [IdxW-1:0]              out_count_q;

  logic                         bh_we;
  logic [BktW-1:0]              bh_waddr;
  logic [IdxW-1:0]              bh_wdata, bh_rdata;
  logic                         ln_we;
  logic [AddrW-1:0]             ln_waddr, ln_raddr;
  logic [IdxW-1:0]              ln_wdata, ln_rdata;
  logic [cht_pkg::KeyBits-1:0]  key_rdata;
  logic [ValueBits-1:0]         val_rdata;
  logic [IdxW-1:0]              free_next;

  // 64-bit integer mixing, split over the hash1, hash2 and hash3 steps
  assign t1   = ~h_q + (h_q << 18);
  assign t2   = h_q + (h_q << 2) + (h_q << 4);
  assign t3   = h_q + (h_q << 6);
  assign hmix = (h_q[31:0] >> 3) ^ cht_pkg::HashXor;
  assign bkt  = hmix[BktW-1:0];

  // slots at or above the high-water mark were never written: they link to the next slot
  assign free_next = (free_q >= hw_q) ? (free_q + IdxW'(1)) : ln_rdata;

  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = bkt;
    bh_wdata = free_q;
    if (cmd_i.clr_wr) begin
      bh_we    = 1'b1;
      bh_waddr = clr_q;
      bh_wdata = Nil;
    end else if (cmd_i.alloc_wr) begin
      bh_we = 1'b1;
    end else if (cmd_i.unlink_wr && prev_q == Nil) begin
      bh_we    = 1'b1;
      bh_wdata = nxt_q;
    end
  end

  always_comb begin
    ln_we    = 1'b0;
    ln_waddr = free_q[AddrW-1:0];
    ln_wdata = head_q;
    if (cmd_i.alloc_wr) begin
      ln_we = 1'b1;
    end else if (cmd_i.unlink_wr && prev_q != Nil) begin
      ln_we    = 1'b1;
      ln_waddr = prev_q[AddrW-1:0];
      ln_wdata = nxt_q;
    end else if (cmd_i.free_wr) begin
      ln_we    = 1'b1;
      ln_waddr = cur_q[AddrW-1:0];
      ln_wdata = free_q;
    end
  end

  assign ln_raddr = cmd_i.alloc_rd ? free_q[AddrW-1:0] : cur_q[AddrW-1:0];

  cht_ram #(.Width(IdxW), .Depth(Buckets)) u_heads (
    .clk_i, .we_i(bh_we), .waddr_i(bh_waddr), .wdata_i(bh_wdata),
    .raddr_i(bkt), .rdata_o(bh_rdata)
  );

  cht_ram #(.Width(IdxW), .Depth(Entries)) u_links (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .raddr_i(ln_raddr), .rdata_o(ln_rdata)
  );

  cht_ram #(.Width(cht_pkg::KeyBits), .Depth(Entries)) u_keys (
    .clk_i, .we_i(cmd_i.alloc_wr), .waddr_i(free_q[AddrW-1:0]), .wdata_i(key_q),
    .raddr_i(cur_q[AddrW-1:0]), .rdata_o(key_rdata)
  );

  cht_ram #(.Width(ValueBits), .Depth(Entries)) u_values (
    .clk_i, .we_i(cmd_i.alloc_wr), .waddr_i(free_q[AddrW-1:0]), .wdata_i(val_q),
    .raddr_i(cur_q[AddrW-1:0]), .rdata_o(val_rdata)
  );

  // request payload and hash
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      val_q  <= value_i;
      h_q    <= key_i;
    end else if (cmd_i.hash1) begin
      h_q <= t1 ^ (t1 >> 31);
    end else if (cmd_i.hash2) begin
      h_q <= t2 ^ (t2 >> 11);
    end else if (cmd_i.hash3) begin
      h_q <= t3 ^ (t3 >> 22);
    end
  end

  // chain walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_load) begin
      cur_q  <= bh_rdata;
      head_q <= bh_rdata;
      prev_q <= Nil;
    end else if (cmd_i.compare) begin
      nxt_q <= ln_rdata;
      if (key_rdata != key_q) begin
        prev_q <= cur_q;
        cur_q  <= ln_rdata;
      end
    end
    if (cmd_i.accept) begin
      found_q <= '0;
    end else if (cmd_i.found_load) begin
      found_q <= val_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '0;
      hw_q        <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + BktW'(1);
      if (cmd_i.alloc_wr) begin
        free_q  <= free_next;
        count_q <= count_q + IdxW'(1);
        if (free_q >= hw_q) hw_q <= free_q + IdxW'(1);
      end else if (cmd_i.free_wr) begin
        free_q <= cur_q;
        if (count_q != '0) count_q <= count_q - IdxW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.res_status;
      out_found_q  <= found_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.clr_last  = (clr_q == BktW'(Buckets - 1));
  assign stat_o.cur_nil   = (cur_q == Nil);
  assign stat_o.key_match = (key_rdata == key_q);
  assign stat_o.free_nil  = (free_q == Nil);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign stat_o.kind      = kind_q;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;
  assign out_count_o  = out_count_q;

endmodule

// ===== tb/sv/chained_hash_table_tb.sv =====
// Self-checking testbench for the chained hash table: directed table, then random traffic.
module chained_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Buckets   = cht_pkg::DefBuckets;
  localparam int unsigned Entries   = cht_pkg::DefEntries;
  localparam int unsigned IdxW      = $clog2(Entries + 1);
  localparam logic [IdxW-1:0] NilIdx = IdxW'(Entries);
  localparam int unsigned CycleLimit = 400000;
  localparam logic [cht_pkg::KindBits-1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic [cht_pkg::StatusBits-1:0] status;
    logic [31:0]                    found;
    logic [IdxW-1:0]                count;
  } answer_t;

  typedef struct {
    logic [cht_pkg::KindBits-1:0] kind;
    logic [63:0]                  key;
    logic [31:0]                  value;
    bit                           typed;
    answer_t                      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // key [63:0], value [95:64]
  logic [1:0]  s_axis_tuser = '0;   // kind [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // status [1:0], found_value [33:2], entry_count [44:34]

  chained_hash_table uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow table
  logic [IdxW-1:0] head_mem [Buckets];
  logic [63:0]     key_mem  [Entries];
  logic [31:0]     val_mem  [Entries];
  logic [IdxW-1:0] link_mem [Entries];
  logic [IdxW-1:0] free_top;
  int unsigned     held;

  answer_t answers_due[$];
  int unsigned errors = 0;
  int unsigned answers_seen = 0;
  int unsigned full_hits = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  function automatic int unsigned bucket_of(logic [63:0] k);
    logic [63:0] h;
    logic [31:0] lo;
    h = (~k) + (k << 18);
    h = h ^ (h >> 31);
    h = h * 64'd21;
    h = h ^ (h >> 11);
    h = h + (h << 6);
    h = h ^ (h >> 22);
    lo = h[31:0];
    return ((lo >> 3) ^ cht_pkg::HashXor) % Buckets;
  endfunction

  task automatic table_clear();
    for (int i = 0; i < Buckets; i++) head_mem[i] = NilIdx;
    for (int i = 0; i < Entries; i++) begin
      key_mem[i] = '0;
      val_mem[i] = '0;
      link_mem[i] = IdxW'(i + 1);
    end
    free_top = '0;
    held = 0;
  endtask

  task automatic table_apply(input logic [cht_pkg::KindBits-1:0] kind,
                             input logic [63:0] key,
                             input logic [31:0] value, output answer_t ans);
    int unsigned b;
    logic [IdxW-1:0] cur, prev, hit, slot;
    int unsigned steps;
    b = bucket_of(key);
    cur = head_mem[b];
    prev = NilIdx;
    hit = NilIdx;
    steps = 0;
    while (cur < NilIdx && steps < Entries && hit == NilIdx) begin
      if (key_mem[cur] == key) hit = cur;
      else begin
        prev = cur;
        cur = link_mem[cur];
        steps++;
      end
    end
    ans.status = cht_pkg::ST_NOT_FOUND;
    ans.found = '0;
    case (kind)
      cht_pkg::KIND_INSERT: begin
        if (hit < NilIdx) ans.status = cht_pkg::ST_PRESENT;
        else if (free_top >= NilIdx) begin
          ans.status = cht_pkg::ST_POOL_FULL;
          full_hits++;
        end else begin
          slot = free_top;
          free_top = link_mem[slot];
          key_mem[slot] = key;
          val_mem[slot] = value;
          link_mem[slot] = head_mem[b];
          head_mem[b] = slot;
          held++;
          ans.status = cht_pkg::ST_OK;
        end
      end
      cht_pkg::KIND_SEARCH: begin
        if (hit < NilIdx) begin
          ans.status = cht_pkg::ST_OK;
          ans.found = val_mem[hit];
        end
      end
      cht_pkg::KIND_REMOVE: begin
        if (hit < NilIdx) begin
          if (prev < NilIdx) link_mem[prev] = link_mem[hit];
          else head_mem[b] = link_mem[hit];
          ans.found = val_mem[hit];
          link_mem[hit] = free_top;
          free_top = hit;
          if (held > 0) held--;
          ans.status = cht_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    ans.count = IdxW'(held);
  endtask

  // Offer one request; called and returns at a falling edge.
  task automatic offer(input logic [cht_pkg::KindBits-1:0] kind, input logic [63:0] key,
                       input logic [31:0] value, input bit typed, input answer_t want);
    answer_t got;
    while (!steady && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {value, key};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    table_apply(kind, key, value, got);
    answers_due.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off once traffic is flowing.
  initial begin
    int unsigned hold;
    bit held_off;
    held_off = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (!held_off && answers_seen >= 60) begin
        held_off = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.found  = m_axis_tdata[33:2];
      got.count  = m_axis_tdata[44:34];
      answers_seen++;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = answers_due.pop_front();
        if (got.status != want.status) begin
          errors++;
          $display("%0t: status exp %0d act %0d", $time, want.status, got.status);
        end
        if (got.found != want.found) begin
          errors++;
          $display("%0t: found_value exp %h act %h", $time, want.found, got.found);
        end
        if (got.count != want.count) begin
          errors++;
          $display("%0t: entry_count exp %0d act %0d", $time, want.count, got.count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    logic [63:0] ones, topbit, k;
    logic [63:0] pool_keys[48];
    logic [63:0] fresh[$];
    logic [cht_pkg::KindBits-1:0] kd;
    int unsigned pick, n;
    answer_t nil_ans;
    ones = '1;
    topbit = 64'h8000_0000_0000_0000;
    nil_ans = '0;
    rows = '{
      '{cht_pkg::KIND_SEARCH, 64'd0, 32'h0, 1'b1, '{cht_pkg::ST_NOT_FOUND, 32'h0, 11'd0}},
      '{cht_pkg::KIND_REMOVE, ones, 32'hFFFF_FFFF, 1'b1,
        '{cht_pkg::ST_NOT_FOUND, 32'h0, 11'd0}},
      '{KindUnused, 64'd5, 32'h1, 1'b1, '{cht_pkg::ST_NOT_FOUND, 32'h0, 11'd0}},
      '{cht_pkg::KIND_INSERT, 64'd0, 32'hFFFF_FFFF, 1'b1, '{cht_pkg::ST_OK, 32'h0, 11'd1}},
      '{cht_pkg::KIND_INSERT, ones, 32'h0, 1'b1, '{cht_pkg::ST_OK, 32'h0, 11'd2}},
      '{cht_pkg::KIND_INSERT, 64'd0, 32'h5, 1'b1, '{cht_pkg::ST_PRESENT, 32'h0, 11'd2}},
      '{cht_pkg::KIND_SEARCH, 64'd0, 32'h0, 1'b1, '{cht_pkg::ST_OK, 32'hFFFF_FFFF, 11'd2}},
      '{cht_pkg::KIND_SEARCH, ones, 32'h0, 1'b1, '{cht_pkg::ST_OK, 32'h0, 11'd2}},
      '{cht_pkg::KIND_INSERT, 64'd1, 32'h8000_0000, 1'b1, '{cht_pkg::ST_OK, 32'h0, 11'd3}},
      '{cht_pkg::KIND_INSERT, topbit, 32'h1, 1'b1, '{cht_pkg::ST_OK, 32'h0, 11'd4}},
      '{KindUnused, 64'd0, 32'h0, 1'b1, '{cht_pkg::ST_NOT_FOUND, 32'h0, 11'd4}},
      '{cht_pkg::KIND_REMOVE, 64'd0, 32'h0, 1'b1, '{cht_pkg::ST_OK, 32'hFFFF_FFFF, 11'd3}},
      '{cht_pkg::KIND_SEARCH, 64'd0, 32'h0, 1'b1, '{cht_pkg::ST_NOT_FOUND, 32'h0, 11'd3}},
      '{cht_pkg::KIND_REMOVE, 64'd0, 32'h0, 1'b1, '{cht_pkg::ST_NOT_FOUND, 32'h0, 11'd3}},
      '{cht_pkg::KIND_INSERT, 64'd0, 32'h1234, 1'b1, '{cht_pkg::ST_OK, 32'h0, 11'd4}},
      '{cht_pkg::KIND_REMOVE, 64'd1, 32'h0, 1'b1, '{cht_pkg::ST_OK, 32'h8000_0000, 11'd3}},
      '{cht_pkg::KIND_SEARCH, topbit, 32'h0, 1'b1, '{cht_pkg::ST_OK, 32'h1, 11'd3}},
      '{cht_pkg::KIND_SEARCH, 64'h5555_AAAA_0F0F_F0F0, 32'h0, 1'b0,
        '{cht_pkg::ST_OK, 32'h0, 11'd0}}
    };
    for (int i = 0; i < 48; i++) pool_keys[i] = {$urandom, $urandom};
    table_clear();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i])
      offer(rows[i].kind, rows[i].key, rows[i].value, rows[i].typed, rows[i].want);

    // Churn over a small key set so inserts, hits and removes all meet.
    for (int i = 0; i < 700; i++) begin
      steady = (i >= 250 && i < 400);
      pick = $urandom_range(99);
      kd = pick < 40 ? cht_pkg::KIND_INSERT : pick < 70 ? cht_pkg::KIND_SEARCH :
           pick < 95 ? cht_pkg::KIND_REMOVE : KindUnused;
      k = ($urandom_range(9) == 0) ? {$urandom, $urandom} : pool_keys[$urandom_range(47)];
      offer(kd, k, $urandom, 1'b0, nil_ans);
    end
    steady = 1'b0;

    // Fill the pool with fresh keys, then knock on it a few more times.
    n = 0;
    while (n < 10) begin
      k = {$urandom, $urandom};
      fresh.push_back(k);
      if (held >= Entries) n++;
      offer(cht_pkg::KIND_INSERT, k, $urandom, 1'b0, nil_ans);
    end

    // Drain: searches and removes through long chains, with occasional inserts.
    for (int i = 0; i < 230; i++) begin
      pick = $urandom_range(99);
      kd = pick < 55 ? cht_pkg::KIND_REMOVE : pick < 90 ? cht_pkg::KIND_SEARCH :
           cht_pkg::KIND_INSERT;
      k = ($urandom_range(7) == 0) ? {$urandom, $urandom} :
          fresh[$urandom_range(fresh.size() - 1)];
      offer(kd, k, $urandom, 1'b0, nil_ans);
    end
    s_axis_tvalid <= 1'b0;

    wait (answers_due.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("covered %0d results, %0d pool-full answers, %0d entries left", answers_seen,
             full_hits, held);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cht_pkg.sv
hdl/cht_ram.sv
hdl/cht_ctrl.sv
hdl/cht_dpath.sv
hdl/chained_hash_table.sv
tb/sv/chained_hash_table_tb.sv
